>>> sv/wsdf_pkg.sv
package wsdf_pkg;

  localparam int unsigned LenW = 64;
  localparam int unsigned AccW = 64;

  localparam logic [LenW-1:0] LEN_MAX = '1;

  localparam logic [6:0] LEN7_MAX_SHORT = 7'd125;
  localparam logic [6:0] LEN7_EXT16     = 7'd126;
  localparam logic [3:0] EXT16_BYTES    = 4'd2;
  localparam logic [3:0] EXT64_BYTES    = 4'd8;
  localparam logic [1:0] KEY_LAST_IDX   = 2'd3;

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    K_START = 2'd0,
    K_DATA  = 2'd1,
    K_END   = 2'd2,
    K_ERROR = 2'd3
  } kind_t;

  localparam logic CAUSE_CONT_OPCODE = 1'b0;
  localparam logic CAUSE_LEN_TOP     = 1'b1;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [3:0] opcode;
    logic [7:0] data_byte;
    logic       message_end;
    logic       error_cause;
  } evt_t;

endpackage

>>> sv/wsdf_byte_if.sv
interface wsdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

>>> sv/wsdf_event_if.sv
interface wsdf_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] opcode;
  logic [7:0] data_byte;
  logic       message_end;
  logic       error_cause;

  modport source (output valid, output kind, output opcode, output data_byte,
                  output message_end, output error_cause, input ready);
  modport sink   (input valid, input kind, input opcode, input data_byte,
                  input message_end, input error_cause, output ready);
endinterface

>>> sv/wsdf_parser.sv
module wsdf_parser import wsdf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] in_byte,
  output evt_t       evt
);

  phase_t            phase_r, phase_nxt;
  logic              final_r, final_nxt;
  logic              cont_r, cont_nxt;
  logic              mask_r, mask_nxt;
  logic [LenW-1:0]   len_r, len_nxt;      // frame length, then bytes still to come
  logic [AccW-1:0]   acc_r, acc_nxt;
  logic [3:0]        ext_rem_r, ext_rem_nxt;
  logic [7:0]        key_r [4];
  logic [7:0]        key_nxt [4];
  logic [1:0]        key_idx_r, key_idx_nxt;
  logic [1:0]        pidx_r, pidx_nxt;

  logic [6:0]        len7;
  logic [AccW-1:0]   acc_shift;
  logic [LenW-1:0]   ext_len;
  logic              ext_last;
  logic              hdr_done;
  logic              hdr_mask;
  logic [LenW-1:0]   hdr_len;
  logic              pay_go;
  logic [LenW-1:0]   pay_len;

  assign len7      = in_byte[6:0];
  assign acc_shift = {acc_r[AccW-9:0], in_byte};
  // saturate to the stored length width
  assign ext_len   = (acc_shift > AccW'(LEN_MAX)) ? LEN_MAX : acc_shift[LenW-1:0];
  assign ext_last  = (ext_rem_r <= 4'd1);

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    final_nxt   = final_r;
    cont_nxt    = cont_r;
    mask_nxt    = mask_r;
    len_nxt     = len_r;
    acc_nxt     = acc_r;
    ext_rem_nxt = ext_rem_r;
    key_nxt     = key_r;
    key_idx_nxt = key_idx_r;
    pidx_nxt    = pidx_r;
    hdr_done    = 1'b0;
    hdr_mask    = mask_r;
    hdr_len     = '0;
    pay_go      = 1'b0;
    pay_len     = len_r;
    unique case (phase_r)
      PH_LENGTH: begin
        mask_nxt = in_byte[7];
        hdr_mask = in_byte[7];
        if (len7 > LEN7_MAX_SHORT) begin
          ext_rem_nxt = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          acc_nxt     = '0;
          phase_nxt   = PH_EXTLEN;
        end else begin
          hdr_done = 1'b1;
          hdr_len  = LenW'(len7);
        end
      end
      PH_EXTLEN: begin
        acc_nxt = acc_shift;
        if (ext_rem_r != 4'd0) ext_rem_nxt = ext_rem_r - 4'd1;
        if (ext_last) begin
          hdr_done = 1'b1;
          hdr_len  = ext_len;
        end
      end
      PH_KEY: begin
        key_nxt[key_idx_r] = in_byte;
        key_idx_nxt        = key_idx_r + 2'd1;
        if (key_idx_r == KEY_LAST_IDX) pay_go = 1'b1;
      end
      PH_PAYLOAD: begin
        pidx_nxt = pidx_r + 2'd1;
        len_nxt  = len_r - LenW'(1);
        if (len_r == LenW'(1)) phase_nxt = PH_OPCODE;
      end
      default: begin
        // opcode byte; unused phase codes land here too
        phase_nxt = PH_LENGTH;
        final_nxt = in_byte[7];
        cont_nxt  = ~in_byte[7];
        mask_nxt  = 1'b0;
        for (int i = 0; i < 4; i++) key_nxt[i] = '0;
      end
    endcase

    if (hdr_done) begin
      len_nxt = hdr_len;
      if (hdr_mask) begin
        phase_nxt   = PH_KEY;
        key_idx_nxt = '0;
      end else begin
        pay_go  = 1'b1;
        pay_len = hdr_len;
      end
    end

    if (pay_go) begin
      pidx_nxt  = '0;
      phase_nxt = (pay_len == '0) ? PH_OPCODE : PH_PAYLOAD;
    end
  end

  // event for the word on the input
  always_comb begin
    evt = '{valid: 1'b0, kind: K_START, opcode: 4'd0, data_byte: 8'd0,
            message_end: 1'b0, error_cause: 1'b0};
    unique case (phase_r)
      PH_LENGTH: begin
        if (!in_byte[7] && len7 == 7'd0 && final_r) begin
          evt.valid       = 1'b1;
          evt.kind        = K_END;
          evt.message_end = 1'b1;
        end
      end
      PH_EXTLEN: begin
        if (ext_last) begin
          if (acc_shift[AccW-1]) begin
            evt.valid       = 1'b1;
            evt.kind        = K_ERROR;
            evt.error_cause = CAUSE_LEN_TOP;
          end else if (!mask_r && acc_shift == '0 && final_r) begin
            evt.valid       = 1'b1;
            evt.kind        = K_END;
            evt.message_end = 1'b1;
          end
        end
      end
      PH_KEY: begin
        if (key_idx_r == KEY_LAST_IDX && len_r == '0 && final_r) begin
          evt.valid       = 1'b1;
          evt.kind        = K_END;
          evt.message_end = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        evt.valid       = 1'b1;
        evt.kind        = K_DATA;
        evt.data_byte   = in_byte ^ key_r[pidx_r];
        evt.message_end = (len_r == LenW'(1)) && final_r;
      end
      default: begin
        if (in_byte[3:0] != 4'd0) begin
          evt.valid = 1'b1;
          if (cont_r) begin
            evt.kind        = K_ERROR;
            evt.error_cause = CAUSE_CONT_OPCODE;
          end else begin
            evt.kind   = K_START;
            evt.opcode = in_byte[3:0];
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_OPCODE;
      final_r   <= 1'b0;
      cont_r    <= 1'b0;
      mask_r    <= 1'b0;
      len_r     <= '0;
      acc_r     <= '0;
      ext_rem_r <= '0;
      key_idx_r <= '0;
      pidx_r    <= '0;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      final_r   <= final_nxt;
      cont_r    <= cont_nxt;
      mask_r    <= mask_nxt;
      len_r     <= len_nxt;
      acc_r     <= acc_nxt;
      ext_rem_r <= ext_rem_nxt;
      key_idx_r <= key_idx_nxt;
      pidx_r    <= pidx_nxt;
      key_r     <= key_nxt;
    end
  end

endmodule

>>> sv/wsdf_out_reg.sv
module wsdf_out_reg import wsdf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  evt_t       evt,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_ready,
  output kind_t      out_kind,
  output logic [3:0] out_opcode,
  output logic [7:0] out_data_byte,
  output logic       out_message_end,
  output logic       out_error_cause
);

  logic valid_r, valid_nxt;
  evt_t evt_r;

  // room when empty or when the held word leaves this cycle
  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load)           valid_nxt = evt.valid;
    else if (out_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && evt.valid) begin
      evt_r <= evt;
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = evt_r.kind;
  assign out_opcode      = evt_r.opcode;
  assign out_data_byte   = evt_r.data_byte;
  assign out_message_end = evt_r.message_end;
  assign out_error_cause = evt_r.error_cause;

endmodule

>>> sv/websocket_frame_deframer_unit.sv
// WebSocket (RFC 6455) receive deframer. Takes one stream byte per word on
// in_if and emits at most one event per byte on out_if: message start with
// opcode, unmasked data byte (message_end on the last byte of a fin frame),
// end-only for an empty fin frame, or protocol error (opcode inside a
// continuation, or extended length with the top bit set). The frame state
// updates in a single pass and the event lands in a one-deep output
// register, so with out_if.ready held high a byte is taken every cycle. The
// event is on out_if in the cycle after its byte is taken; in_if.ready drops
// only while an event waits in the output register.
module websocket_frame_deframer_unit import wsdf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  wsdf_byte_if.sink     in_if,
  wsdf_event_if.source  out_if
);

  logic  step;
  logic  can_load;
  evt_t  evt;
  kind_t out_kind;

  assign in_if.ready = can_load;
  assign step        = in_if.valid && can_load;

  wsdf_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_byte (in_if.in_byte),
    .evt     (evt)
  );

  wsdf_out_reg u_out_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (step),
    .evt             (evt),
    .can_load        (can_load),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_kind        (out_kind),
    .out_opcode      (out_if.opcode),
    .out_data_byte   (out_if.data_byte),
    .out_message_end (out_if.message_end),
    .out_error_cause (out_if.error_cause)
  );

  assign out_if.kind = out_kind;

endmodule

>>> verif/websocket_frame_deframer_unit_test.sv
module websocket_frame_deframer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wsdf_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1400;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [6:0]  LEN7_EXT64   = 7'd127;
  localparam logic [63:0] LEN_CAP      = (LenW >= 64) ? '1 : ((64'd1 << LenW) - 64'd1);

  // how a stimulus row is checked: by the predictor, expecting nothing, or as typed
  typedef enum logic [1:0] {
    CHK_CALC  = 2'd0,
    CHK_NONE  = 2'd1,
    CHK_EVENT = 2'd2
  } row_chk_t;

  typedef enum logic [1:0] {
    FORM_SHORT = 2'd0,
    FORM_EXT16 = 2'd1,
    FORM_EXT64 = 2'd2
  } len_form_t;

  typedef struct packed {
    logic [7:0] value;
    row_chk_t   chk;
    evt_t       ev;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wsdf_byte_if  in_if ();
  wsdf_event_if out_if ();

  websocket_frame_deframer_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // row tag travels with the word so the monitor sees it at the accepting edge
  row_chk_t tag_chk;
  evt_t     tag_ev;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_ask;
  bit          hold_served;
  int unsigned bytes_offered;
  int unsigned bytes_taken;
  int unsigned kind_seen [4];
  int unsigned fail_count;
  int unsigned stall_cycles;

  stim_row_t script [$];
  evt_t      pending_events [$];

  // deframer state as predicted
  phase_t      ph_q;
  logic        fin_q;
  logic        cont_q;
  logic        masked_q;
  logic [63:0] frame_len;
  logic [63:0] rx_count;
  logic [63:0] len_accum;
  logic [3:0]  ext_left;
  logic [1:0]  key_idx;
  logic [7:0]  key_q [4];

  function automatic evt_t make_evt(input kind_t k, input logic [3:0] op, input logic [7:0] d,
                                    input logic e, input logic c);
    evt_t ev;
    ev.valid       = 1'b1;
    ev.kind        = k;
    ev.opcode      = op;
    ev.data_byte   = d;
    ev.message_end = e;
    ev.error_cause = c;
    return ev;
  endfunction

  function automatic void clear_frame();
    ph_q      = PH_OPCODE;
    fin_q     = 1'b0;
    masked_q  = 1'b0;
    frame_len = '0;
    rx_count  = '0;
    len_accum = '0;
    ext_left  = '0;
    key_idx   = '0;
    foreach (key_q[k]) key_q[k] = '0;
  endfunction

  function automatic bit open_payload(output evt_t ev);
    bit fin;
    ev = '0;
    if (frame_len != '0) begin
      ph_q     = PH_PAYLOAD;
      rx_count = '0;
      return 1'b0;
    end
    // empty frame: only a fin frame says anything
    fin = fin_q;
    clear_frame();
    if (!fin) return 1'b0;
    ev = make_evt(K_END, 4'd0, 8'd0, 1'b1, 1'b0);
    return 1'b1;
  endfunction

  function automatic bit close_header(output evt_t ev);
    ev = '0;
    if (masked_q) begin
      ph_q    = PH_KEY;
      key_idx = '0;
      return 1'b0;
    end
    return open_payload(ev);
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output evt_t ev);
    evt_t       spare;
    bit         got;
    bit         fin;
    logic [7:0] data;
    ev  = '0;
    got = 1'b0;
    case (ph_q)
      PH_LENGTH: begin
        masked_q = b[7];
        if (b[6:0] > LEN7_MAX_SHORT) begin
          ext_left  = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          len_accum = '0;
          frame_len = '0;
          ph_q      = PH_EXTLEN;
        end else begin
          frame_len = 64'(b[6:0]);
          got = close_header(ev);
        end
      end
      PH_EXTLEN: begin
        len_accum = {len_accum[55:0], b};
        if (ext_left != 0) ext_left--;
        if (ext_left == 0) begin
          frame_len = (len_accum > LEN_CAP) ? LEN_CAP : len_accum;
          if (len_accum[63]) begin
            // length is nonzero here, so the header can add nothing
            ev  = make_evt(K_ERROR, 4'd0, 8'd0, 1'b0, CAUSE_LEN_TOP);
            got = 1'b1;
            void'(close_header(spare));
          end else begin
            got = close_header(ev);
          end
        end
      end
      PH_KEY: begin
        key_q[key_idx] = b;
        if (key_idx == KEY_LAST_IDX) got = open_payload(ev);
        else key_idx++;
      end
      PH_PAYLOAD: begin
        data = b ^ key_q[rx_count[1:0]];
        rx_count++;
        got = 1'b1;
        if (rx_count >= frame_len) begin
          fin = fin_q;
          clear_frame();
          ev = make_evt(K_DATA, 4'd0, data, fin, 1'b0);
        end else begin
          ev = make_evt(K_DATA, 4'd0, data, 1'b0, 1'b0);
        end
      end
      default: begin
        clear_frame();
        fin_q = b[7];
        if (b[3:0] != 4'd0) begin
          got = 1'b1;
          ev  = cont_q ? make_evt(K_ERROR, 4'd0, 8'd0, 1'b0, CAUSE_CONT_OPCODE)
                       : make_evt(K_START, b[3:0], 8'd0, 1'b0, 1'b0);
        end
        cont_q = !fin_q;
        ph_q   = PH_LENGTH;
      end
    endcase
    return got;
  endfunction

  function automatic stim_row_t calc_row(input logic [7:0] b);
    stim_row_t r;
    r       = '0;
    r.value = b;
    r.chk   = CHK_CALC;
    return r;
  endfunction

  function automatic stim_row_t none_row(input logic [7:0] b);
    stim_row_t r;
    r       = '0;
    r.value = b;
    r.chk   = CHK_NONE;
    return r;
  endfunction

  function automatic stim_row_t ev_row(input logic [7:0] b, input kind_t k, input logic [3:0] op,
                                       input logic [7:0] d, input logic e, input logic c);
    stim_row_t r;
    r.value = b;
    r.chk   = CHK_EVENT;
    r.ev    = make_evt(k, op, d, e, c);
    return r;
  endfunction

  task automatic push_byte(input stim_row_t row);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= row.value;
    tag_chk       <= row.chk;
    tag_ev        <= row.ev;
    do @(posedge clk); while (!in_if.ready);
    bytes_offered++;
  endtask

  task automatic play_rows(input int unsigned lo, input int unsigned hi);
    for (int unsigned i = lo; i < hi; i++) push_byte(script[i]);
  endtask

  task automatic send_frame(input logic [7:0] hdr);
    int unsigned len;
    bit          masked;
    len_form_t   form;
    logic [63:0] ext;
    masked = ($urandom_range(9, 0) < 7);
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4, 5: len = $urandom_range(12, 0);
      6, 7, 8:          len = $urandom_range(40, 13);
      default:          len = $urandom_range(200, 41);
    endcase
    case ($urandom_range(19, 0))
      0, 1, 2: form = FORM_EXT16;
      3, 4:    form = FORM_EXT64;
      default: form = (len > 125) ? FORM_EXT16 : FORM_SHORT;
    endcase
    push_byte(calc_row(hdr));
    ext = 64'(len);
    case (form)
      FORM_SHORT: push_byte(calc_row({masked, ext[6:0]}));
      FORM_EXT16: begin
        push_byte(calc_row({masked, LEN7_EXT16}));
        push_byte(calc_row(ext[15:8]));
        push_byte(calc_row(ext[7:0]));
      end
      default: begin
        push_byte(calc_row({masked, LEN7_EXT64}));
        for (int k = 0; k < 8; k++) begin
          push_byte(calc_row(ext[63:56]));
          ext = ext << 8;
        end
      end
    endcase
    if (masked)
      for (int k = 0; k < 4; k++) push_byte(calc_row(8'($urandom_range(255, 0))));
    for (int unsigned n = 0; n < len; n++) push_byte(calc_row(8'($urandom_range(255, 0))));
  endtask

  // mostly well-formed messages of one to three frames; the rest takes any header byte
  task automatic send_message();
    int unsigned frames;
    logic [3:0]  op;
    logic [7:0]  hdr;
    if ($urandom_range(99, 0) < 20) begin
      send_frame(8'($urandom_range(255, 0)));
    end else begin
      frames = $urandom_range(3, 1);
      op     = 4'($urandom_range(15, 1));
      for (int unsigned i = 0; i < frames; i++) begin
        hdr = {i + 1 == frames, 3'b000, (i == 0) ? op : 4'd0};
        if ($urandom_range(9, 0) == 0) hdr[6:4] = 3'($urandom_range(7, 0));
        send_frame(hdr);
      end
    end
  endtask

  always @(posedge clk) begin
    evt_t calc;
    evt_t want;
    bit   got;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        got = deframe_byte(in_if.in_byte, calc);
        bytes_taken++;
        case (tag_chk)
          CHK_CALC:  if (got) pending_events.push_back(calc);
          CHK_EVENT: pending_events.push_back(tag_ev);
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        kind_seen[out_if.kind]++;
        if (pending_events.size() == 0) begin
          $error("unexpected event: kind %0d, data %0h", out_if.kind, out_if.data_byte);
          fail_count++;
        end else begin
          want = pending_events.pop_front();
          if (out_if.kind != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_if.kind);
            fail_count++;
          end
          if (out_if.opcode != want.opcode) begin
            $error("opcode: expected %0d, got %0d", want.opcode, out_if.opcode);
            fail_count++;
          end
          if (out_if.data_byte != want.data_byte) begin
            $error("data_byte: expected %0h, got %0h", want.data_byte, out_if.data_byte);
            fail_count++;
          end
          if (out_if.message_end != want.message_end) begin
            $error("message_end: expected %0d, got %0d", want.message_end, out_if.message_end);
            fail_count++;
          end
          if (out_if.error_cause != want.error_cause) begin
            $error("error_cause: expected %0d, got %0d", want.error_cause, out_if.error_cause);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin : ready_drive
    int unsigned hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask && !hold_served) begin
        hold_left   = HOLD_CYCLES;
        hold_served = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned tail_start;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= 8'h00;
    tag_chk       <= CHK_NONE;
    tag_ev        <= '0;
    send_idle_pct = 22;
    recv_idle_pct = 83;
    hold_ask      = 1'b0;
    hold_served   = 1'b0;
    bytes_offered = 0;
    bytes_taken   = 0;
    fail_count    = 0;
    stall_cycles  = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    clear_frame();
    cont_q = 1'b0;

    script = '{
      ev_row(8'hFF, K_START, 4'd15, 8'h00, 1'b0, 1'b0),   // fin, rsv bits, reserved opcode
      ev_row(8'h00, K_END, 4'd0, 8'h00, 1'b1, 1'b0),      // empty fin frame
      ev_row(8'h02, K_START, 4'd2, 8'h00, 1'b0, 1'b0),    // opens a fragmented message
      none_row(8'h83),
      none_row(8'hFF), none_row(8'h00), none_row(8'hA5), none_row(8'h5A),
      calc_row(8'h00), calc_row(8'hFF), calc_row(8'h12),
      ev_row(8'h09, K_ERROR, 4'd0, 8'h00, 1'b0, CAUSE_CONT_OPCODE),
      none_row(8'h7E), none_row(8'h00), none_row(8'h01),
      ev_row(8'h3C, K_DATA, 4'd0, 8'h3C, 1'b0, 1'b0),
      none_row(8'h80),                                    // fin continuation, no start
      none_row(8'h7F),
      none_row(8'h00), none_row(8'h00), none_row(8'h00), none_row(8'h00),
      none_row(8'h00), none_row(8'h00), none_row(8'h00), none_row(8'h01),
      ev_row(8'h7E, K_DATA, 4'd0, 8'h7E, 1'b1, 1'b0),
      none_row(8'h80),                                    // opcode zero outside a message
      ev_row(8'h00, K_END, 4'd0, 8'h00, 1'b1, 1'b0)
    };
    tail_start = script.size();
    // top-bit length never finishes its payload, so it closes the stream
    script.push_back(calc_row(8'h82));
    script.push_back(none_row(8'hFF));
    script.push_back(none_row(8'h80));
    repeat (6) script.push_back(none_row(8'h00));
    script.push_back(ev_row(8'h05, K_ERROR, 4'd0, 8'h00, 1'b0, CAUSE_LEN_TOP));
    script.push_back(none_row(8'h11));
    script.push_back(none_row(8'h22));
    script.push_back(none_row(8'h33));
    script.push_back(none_row(8'h44));
    script.push_back(ev_row(8'h11, K_DATA, 4'd0, 8'h00, 1'b0, 1'b0));
    script.push_back(calc_row(8'hA7));
    script.push_back(calc_row(8'h5C));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    play_rows(0, tail_start);
    bytes_offered = 0;
    while (bytes_offered < RANDOM_BYTES) begin
      if (bytes_offered >= 2 * RANDOM_BYTES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_ask      = 1'b1;
      end else if (bytes_offered >= RANDOM_BYTES / 3) begin
        send_idle_pct = 83;
        recv_idle_pct = 22;
      end
      send_message();
    end
    play_rows(tail_start, script.size());
    in_if.valid <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d stream words in; events out: %0d start, %0d data,",
             bytes_taken, kind_seen[K_START], kind_seen[K_DATA]);
    $display("summary: %0d end-only, %0d error; fragmented and stray frames, %0d-cycle stall",
             kind_seen[K_END], kind_seen[K_ERROR], HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
